[sv/http_request_line_parser_top_defines.svh]
// Assertion macros used by the request line parser state machine.
`ifndef HTTP_REQUEST_LINE_PARSER_TOP_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HRLP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hrlp_pkg.sv]
// Shared types, constants and character tables for the request line parser.
package hrlp_pkg;

  localparam int unsigned TargetMaxDef = 256;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned IdxW         = 8;
  localparam int unsigned DigitW       = 4;
  localparam int unsigned LenW         = 9;
  localparam int unsigned OutPackW     = 2 * ByteW + 2 + 2 * DigitW + LenW;
  localparam int unsigned OutDataW     = ((OutPackW + 7) / 8) * 8;

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChDot   = 8'h2e;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  localparam logic [2:0] GetLen  = 3'd4;
  localparam logic [2:0] HttpLen = 3'd5;

  typedef enum logic {
    KindTarget  = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic [ByteW-1:0]   target_byte;
    logic [IdxW-1:0]    target_index;
    logic               ok;
    logic               method_get;
    logic [DigitW-1:0]  major;
    logic [DigitW-1:0]  minor;
    logic [LenW-1:0]    target_len;
  } result_t;

  // "GET "
  function automatic logic [ByteW-1:0] get_char(input logic [2:0] pos);
    logic [ByteW-1:0] c;
    case (pos)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h54;
      3'd3:    c = ChSpace;
      default: c = ChNul;
    endcase
    return c;
  endfunction

  // "HTTP/"
  function automatic logic [ByteW-1:0] http_char(input logic [2:0] pos);
    logic [ByteW-1:0] c;
    case (pos)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2f;
      default: c = ChNul;
    endcase
    return c;
  endfunction

endpackage

[sv/hrlp_fsm.sv]
// Parser state machine: per-byte state update and result formation.
`include "http_request_line_parser_top_defines.svh"

module hrlp_fsm #(
  parameter int unsigned TARGET_MAX = hrlp_pkg::TargetMaxDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [hrlp_pkg::ByteW-1:0]  ch_i,
  input  logic                        last_i,
  output hrlp_pkg::result_t           res_o
);

  localparam int unsigned CntW = $clog2(TARGET_MAX + 1);

  typedef enum logic [7:0] {
    PhMethod  = 8'b0000_0001,
    PhTarget  = 8'b0000_0010,
    PhVersion = 8'b0000_0100,
    PhMajor   = 8'b0000_1000,
    PhDot     = 8'b0001_0000,
    PhMinor   = 8'b0010_0000,
    PhDone    = 8'b0100_0000,
    PhFail    = 8'b1000_0000
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [2:0]                    pos_q, pos_d;
  logic [CntW-1:0]               kept_q, kept_d;
  logic                          saw_q, saw_d;
  logic [hrlp_pkg::DigitW-1:0]   maj_q, maj_d;
  logic [hrlp_pkg::DigitW-1:0]   min_q, min_d;
  logic                          is_digit;
  logic                          ok;

  assign is_digit = (ch_i >= hrlp_pkg::ChZero) && (ch_i <= hrlp_pkg::ChNine);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    kept_d  = kept_q;
    saw_d   = saw_q;
    maj_d   = maj_q;
    min_d   = min_q;
    res_o   = '0;

    case (phase_q)
      PhMethod: begin
        if (pos_q < hrlp_pkg::GetLen && ch_i == hrlp_pkg::get_char(pos_q)) begin
          if (pos_q == hrlp_pkg::GetLen - 3'd1) begin
            saw_d   = 1'b1;
            phase_d = PhTarget;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end else begin
          phase_d = PhFail;
        end
      end
      PhTarget: begin
        if (ch_i == hrlp_pkg::ChSpace) begin
          phase_d = PhVersion;
          pos_d   = '0;
        end else if (ch_i == hrlp_pkg::ChNul || last_i) begin
          phase_d = PhFail;
        end else if (kept_q < CntW'(TARGET_MAX)) begin
          res_o.valid        = 1'b1;
          res_o.kind         = hrlp_pkg::KindTarget;
          res_o.target_byte  = ch_i;
          res_o.target_index = hrlp_pkg::IdxW'(kept_q);
          kept_d             = kept_q + CntW'(1);
        end
      end
      PhVersion: begin
        if (pos_q < hrlp_pkg::HttpLen && ch_i == hrlp_pkg::http_char(pos_q)) begin
          if (pos_q == hrlp_pkg::HttpLen - 3'd1) begin
            phase_d = PhMajor;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end else begin
          phase_d = PhFail;
        end
      end
      PhMajor: begin
        if (is_digit) begin
          maj_d   = ch_i[hrlp_pkg::DigitW-1:0];
          phase_d = PhDot;
        end else begin
          phase_d = PhFail;
        end
      end
      PhDot: begin
        phase_d = (ch_i == hrlp_pkg::ChDot) ? PhMinor : PhFail;
      end
      PhMinor: begin
        if (is_digit) begin
          min_d   = ch_i[hrlp_pkg::DigitW-1:0];
          phase_d = PhDone;
        end else begin
          phase_d = PhFail;
        end
      end
      default: ;
    endcase

    ok = (phase_d == PhDone);

    if (last_i) begin
      res_o              = '0;
      res_o.valid        = 1'b1;
      res_o.kind         = hrlp_pkg::KindVerdict;
      res_o.ok           = ok;
      res_o.method_get   = saw_d;
      res_o.major        = ok ? maj_d : '0;
      res_o.minor        = ok ? min_d : '0;
      res_o.target_len   = hrlp_pkg::LenW'(kept_d);
      phase_d            = PhMethod;
      pos_d              = '0;
      kept_d             = '0;
      saw_d              = 1'b0;
      maj_d              = '0;
      min_d              = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMethod;
      pos_q   <= '0;
      kept_q  <= '0;
      saw_q   <= 1'b0;
      maj_q   <= '0;
      min_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      kept_q  <= kept_d;
      saw_q   <= saw_d;
      maj_q   <= maj_d;
      min_q   <= min_d;
    end
  end

  `HRLP_ASSERT_NEXT(a_line_end_rearms, step_i && last_i, phase_q == PhMethod && kept_q == '0 && !saw_q, "parser not rearmed after line end")
  `HRLP_ASSERT(a_no_target_on_last, res_o.valid && res_o.kind == hrlp_pkg::KindTarget, !last_i && phase_q == PhTarget, "target word outside target phase")
  `HRLP_ASSERT(a_kept_bounded, 1'b1, kept_q <= CntW'(TARGET_MAX), "target count above limit")
  `HRLP_ASSERT(a_ok_needs_get, step_i && res_o.valid && res_o.ok, res_o.method_get && saw_q, "success verdict without GET prefix")

endmodule

[sv/http_request_line_parser_top.sv]
// Request line parser top level: input register, parser, result register.
// Takes one byte per cycle with back-to-back words while the output is not
// stalled; each word is registered, parsed by the state update and its result,
// if any, lands in the output register. Target bytes come out as tuser 0, the
// verdict on the byte flagged tlast as tuser 1; the parser then rearms for the
// next line. The sustained rate of one byte per cycle, when the output is not
// stalled, is set by the single state update.
module http_request_line_parser_top #(
  parameter int unsigned TARGET_MAX = hrlp_pkg::TargetMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] ch
  input  logic                          s_axis_tlast,   // line_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] target_byte, [15:8] target_index, [16] ok, [17] method_get,
  // [21:18] major, [25:22] minor, [34:26] target_len, rest zero
  output logic [hrlp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tuser    // kind
);

  logic                          in_v_q;
  logic [hrlp_pkg::ByteW-1:0]    in_ch_q;
  logic                          in_last_q;
  logic                          out_v_q, out_v_d;
  logic [hrlp_pkg::OutDataW-1:0] out_data_q;
  logic                          out_user_q;
  logic                          out_free;
  logic                          adv;
  logic                          load;
  hrlp_pkg::result_t             res;

  assign out_free      = !out_v_q || m_axis_tready;
  assign adv           = in_v_q && out_free;
  assign s_axis_tready = !in_v_q || adv;
  assign load          = adv && res.valid;
  assign out_v_d       = out_free ? load : out_v_q;

  hrlp_fsm #(
    .TARGET_MAX (TARGET_MAX)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .ch_i   (in_ch_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (load) begin
      out_data_q <= hrlp_pkg::OutDataW'({res.target_len, res.minor, res.major,
                                         res.method_get, res.ok,
                                         res.target_index, res.target_byte});
      out_user_q <= res.kind;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
